[src/imu_angle_frame_heading_assert.svh]
// Assertion macros shared by the heading parser.
// Both macros use the clock and reset of the module that expands them.
`ifndef IMU_ANGLE_FRAME_HEADING_ASSERT_SVH
`define IMU_ANGLE_FRAME_HEADING_ASSERT_SVH

// Same-cycle implication.
`define IAFH_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("imu_angle_frame_heading: same-cycle check failed");

// Implication whose consequent is checked in the next cycle.
`define IAFH_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("imu_angle_frame_heading: next-cycle check failed");

`endif

[src/iafh_pkg.sv]
package iafh_pkg;

   localparam int unsigned POS_W = 4;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'h53;

   localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
   localparam logic [POS_W-1:0] POS_HDR2   = 4'd1;
   localparam logic [POS_W-1:0] POS_BODY   = 4'd2;
   localparam logic [POS_W-1:0] POS_YAW_LO = 4'd6;
   localparam logic [POS_W-1:0] POS_YAW_HI = 4'd7;
   localparam logic [POS_W-1:0] POS_CHECK  = 4'd10;

   typedef struct packed {
      logic        done;
      logic [15:0] heading;
      logic        heading_valid;
      logic        checksum_ok;
   } frame_result_type;

endpackage

[src/iafh_parser.sv]
module iafh_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic [7:0]                rx_byte,
   output iafh_pkg::frame_result_type result
);

   logic [iafh_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [15:0]                yaw_ff, yaw_in;
   logic [7:0]                 sum_add;
   logic                       hunting;

   assign sum_add = sum_ff + rx_byte;
   assign hunting = (pos_ff == iafh_pkg::POS_HUNT) || (pos_ff > iafh_pkg::POS_CHECK);

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      yaw_in = yaw_ff;
      // A header miss restarts the hunt on the current byte, so 0x55 0x55 slides by one.
      if (hunting || ((pos_ff == iafh_pkg::POS_HDR2) && (rx_byte != iafh_pkg::HDR_SECOND))) begin
         yaw_in = 16'd0;
         if (rx_byte == iafh_pkg::HDR_FIRST) begin
            pos_in = iafh_pkg::POS_HDR2;
            sum_in = iafh_pkg::HDR_FIRST;
         end else begin
            pos_in = iafh_pkg::POS_HUNT;
            sum_in = 8'd0;
         end
      end else if (pos_ff == iafh_pkg::POS_CHECK) begin
         pos_in = iafh_pkg::POS_HUNT;
         sum_in = 8'd0;
         yaw_in = 16'd0;
      end else begin
         pos_in = pos_ff + 4'd1;
         sum_in = sum_add;
         if (pos_ff == iafh_pkg::POS_YAW_LO) begin
            yaw_in = {yaw_ff[15:8], rx_byte};
         end else if (pos_ff == iafh_pkg::POS_YAW_HI) begin
            yaw_in = {rx_byte, yaw_ff[7:0]};
         end
      end
   end

   // Heading is the two's complement of the raw yaw; zero yaw yields zero.
   always_comb begin
      result.done          = (pos_ff == iafh_pkg::POS_CHECK);
      result.heading       = ~yaw_ff + 16'd1;
      result.heading_valid = (yaw_ff != 16'd0);
      result.checksum_ok   = (sum_ff == rx_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= iafh_pkg::POS_HUNT;
         sum_ff <= 8'd0;
         yaw_ff <= 16'd0;
      end else if (step_en) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         yaw_ff <= yaw_in;
      end
   end

endmodule

[src/imu_angle_frame_heading.sv]
// Channel   Dir  Word                                     Handshake
// req_      in   tdata[7:0] = rx_byte                     tvalid / tready
// rsp_      out  tdata[15:0] = heading,                   tvalid / tready
//                tuser[0] = heading_valid, [1] = checksum_ok
//
// One byte per cycle unless a result stalls; byte register and parser step together.
// A result word is registered in the output register after its checksum byte leaves the byte register.
// Synchronous active-high reset returns the parser to header hunting.
// A stalled result blocks only a checksum byte; other bytes keep flowing while the result waits.
module imu_angle_frame_heading (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] heading
   output logic [1:0]  rsp_tuser    // [0] heading_valid, [1] checksum_ok
);

`include "imu_angle_frame_heading_assert.svh"

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                heading_ff;
   logic [1:0]                 flags_ff;
   logic                       advance;
   logic                       req_accept;
   iafh_pkg::frame_result_type result;

   iafh_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign advance    = in_valid_ff && (!result.done || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && result.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && result.done) begin
         heading_ff <= result.heading_valid ? result.heading : 16'd0;
         flags_ff   <= {result.checksum_ok, result.heading_valid};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = heading_ff;
   assign rsp_tuser  = flags_ff;

   `IAFH_ASSERT_NOW(a_invalid_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 16'd0)
   `IAFH_ASSERT_NOW(a_valid_nonzero, rsp_tvalid && rsp_tuser[0], rsp_tdata != 16'd0)
   `IAFH_ASSERT_NOW(a_ready_when_empty, !rsp_valid_ff, req_tready)
   `IAFH_ASSERT_NEXT(a_check_byte_held,
      in_valid_ff && result.done && rsp_valid_ff && !rsp_tready,
      in_valid_ff && $stable(in_byte_ff))

endmodule
